// File: hw/rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants for the tile palette dedup encoder.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int STORE_DEPTH       = 256;  // entries addressable by an 8-bit index
  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int KEY_W             = 24;   // {attr, row, col} as packed on tdata
  localparam int IDX_W             = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } tpd_state_t;

  // Result handed from the search controller to the output register
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic             new_entry;
    logic             overflow;
    logic             last;
  } tpd_result_t;

endpackage

// File: hw/rtl/tile_palette_dedup_encoder_unit.sv
// ----------------------------------------------------------------------------
// tile_palette_dedup_encoder_unit
// Maps tile triples to palette indexes, appending unseen triples.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one beat per map tile, tdata = {attr_mask, frame_row,
//    frame_col} with frame_col in the low byte, tlast = last tile of the map.
//  - Master stream: one beat per tile, tdata = palette_index, tuser[0] =
//    new_entry, tuser[1] = overflow, tlast = end_of_map.
//  - Each tile is looked up by a linear scan of the palette memory, one
//    entry read per cycle (single read port, registered read data). A hit
//    ends the scan at the matching entry; a miss reads all N stored entries.
//    The next tile is accepted in the cycle after the result is registered,
//    so a tile waits for the previous result to reach the output register.
//  - A miss appends the triple at the end of the table (new_entry = 1); a
//    miss with a full table returns index 0 with overflow = 1.
//  - After a tlast tile the entry count drops to zero; old contents are
//    simply ignored, so no clearing pass is needed.
//  - Reset (rst, synchronous) empties the table and the output register.
//  - The result sits in an output register: the next tile is accepted and
//    searched while it waits, and only its hand-off stalls on tready.
//  - Capacity is min(TABLE_DEPTH, 256) since the index is 8 bits.
// ----------------------------------------------------------------------------
module tile_palette_dedup_encoder_unit
  import tpd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] frame_col, [15:8] frame_row, [23:16] attr_mask
  input  logic        s_axis_tlast,   // last_tile
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] palette_index
  output logic [1:0]  m_axis_tuser,   // [0] new_entry, [1] overflow
  output logic        m_axis_tlast    // end_of_map
);

  localparam int CAP = (TABLE_DEPTH < STORE_DEPTH) ? TABLE_DEPTH : STORE_DEPTH;
  localparam int AW  = $clog2(CAP);

  tpd_result_t      res;
  logic             res_take;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;

  // output register free, or emptying this cycle
  assign res_take = !m_axis_tvalid || m_axis_tready;

  tpd_ctrl #(
    .DEPTH(CAP)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_key   (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .res      (res),
    .res_take (res_take),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // Writes land only at the end of a scan; the next read of that entry
  // comes only in a later search, so no forwarding is needed.
  tpd_mem #(
    .DEPTH(CAP)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      m_axis_tdata <= res.index;
      m_axis_tuser <= {res.overflow, res.new_entry};
      m_axis_tlast <= res.last;
    end
  end

endmodule

// File: hw/rtl/tpd_mem.sv
// ----------------------------------------------------------------------------
// tpd_mem
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpd_mem
  import tpd_pkg::*;
#(
  parameter int DEPTH = STORE_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [KEY_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/tpd_ctrl.sv
// ----------------------------------------------------------------------------
// tpd_ctrl
// Search sequencer: linear scan of the valid entries, append on miss.
// ----------------------------------------------------------------------------
module tpd_ctrl
  import tpd_pkg::*;
#(
  parameter int DEPTH = STORE_DEPTH,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  // input beat
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KEY_W-1:0] in_key,
  input  logic             in_last,
  // result toward the output register
  output tpd_result_t      res,
  input  logic             res_take,
  // palette store
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [KEY_W-1:0] wr_data,
  output logic [AW-1:0]    rd_addr,
  input  logic [KEY_W-1:0] rd_data
);

  tpd_state_t       state, state_next;
  logic [KEY_W-1:0] key;
  logic             last;
  logic [CW-1:0]    count;
  logic [CW-1:0]    ptr;
  logic             rd_pending;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    res_idx;
  logic             res_new;
  logic             res_ovf;

  logic hit;
  logic issue;
  logic miss_done;
  logic has_room;

  // compare the entry read last cycle; keep issuing while entries remain
  assign hit       = rd_pending && (rd_data == key);
  assign issue     = (ptr < count) && !hit;
  assign miss_done = !hit && !issue && !rd_pending;
  assign has_room  = count < CW'(DEPTH);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (hit || miss_done) state_next = ST_DONE;
      ST_DONE: if (res_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    rd_addr       = ptr[AW-1:0];
    wr_en         = (state == ST_SCAN) && miss_done && has_room;
    wr_addr       = count[AW-1:0];
    wr_data       = key;
    res.valid     = (state == ST_DONE);
    res.index     = IDX_W'(res_idx);
    res.new_entry = res_new;
    res.overflow  = res_ovf;
    res.last      = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= (state == ST_SCAN) && issue;
      if (state == ST_SCAN && wr_en) begin
        count <= count + CW'(1);
      end else if (state == ST_DONE && res_take && last) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          key <= in_key;
          last <= in_last;
        end
        ptr <= '0;
      end
      ST_SCAN: begin
        if (issue) begin
          ptr    <= ptr + CW'(1);
          rd_idx <= ptr[AW-1:0];
        end
        if (hit) begin
          res_idx <= rd_idx;
          res_new <= 1'b0;
          res_ovf <= 1'b0;
        end else if (miss_done) begin
          res_idx <= has_room ? count[AW-1:0] : '0;
          res_new <= has_room;
          res_ovf <= !has_room;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/tpd_checker.sv
// ----------------------------------------------------------------------------
// tpd_checker
// Port-level checks for the tile palette dedup encoder.
// ----------------------------------------------------------------------------
module tpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // a beat is never both appended and overflowed
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("new_entry and overflow both set");

  // overflow reports index zero
  a_ovf_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 8'd0)
    else $error("overflow with nonzero index");

  // one tile at a time: input closes right after a beat is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready during search");

endmodule

bind tile_palette_dedup_encoder_unit tpd_checker u_tpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/tb_tile_palette_dedup_encoder_unit.sv
// ----------------------------------------------------------------------------
// tb_tile_palette_dedup_encoder_unit
// Self-checking bench for the tile palette dedup encoder. Tile beats go into
// the slave stream. A local palette table predicts each result beat: a repeat
// gives the stored index, a miss appends the triple, and a miss on a full
// table gives overflow with index 0. A tlast beat empties the table. The
// bench runs directed corner tiles, whole-table fills with overflow, random
// maps drawn from small triple pools, and a long result hold-off, under
// three mixes of idle cycles on the two sides.
// ----------------------------------------------------------------------------
module tb_tile_palette_dedup_encoder_unit;
  import tpd_pkg::*;

  localparam int    CLK_PERIOD   = 20;
  localparam int    PALETTE_CAP  = (TABLE_DEPTH_DEF < STORE_DEPTH) ? TABLE_DEPTH_DEF
                                                                 : STORE_DEPTH;
  localparam int    SCAN_CYCLES  = PALETTE_CAP + 8;   // longest search plus margin
  localparam int    HOLD_CYCLES  = 600;               // long result hold-off
  localparam longint LIMIT_CYCLES = 5_000_000;

  // Expected result of one tile
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             fresh;
    logic             overflow;
    logic             end_of_map;
  } tile_code_t;

  // DUT ports; all inputs known from time zero
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [7:0] frame_col, [15:8] frame_row, [23:16] attr_mask
  logic        s_axis_tlast  = 1'b0; // last_tile
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] palette_index
  logic [1:0]  m_axis_tuser;         // [0] new_entry, [1] overflow
  logic        m_axis_tlast;         // end_of_map

  // Predictor state: mirror of the palette table
  logic [KEY_W-1:0] palette [PALETTE_CAP];
  int               entry_count = 0;

  tile_code_t pending_codes [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int n_beats = 0, n_fresh = 0, n_repeat = 0, n_overflow = 0, n_maps = 0;

  // Hold-off request: a toggle seen by the receiver process, which counts
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  tile_palette_dedup_encoder_unit #(
    .TABLE_DEPTH(TABLE_DEPTH_DEF)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Palette lookup: first match among valid entries, else append or overflow.
  // The table empties after a last tile, whatever the tile's outcome.
  function automatic tile_code_t encode_tile(input logic [KEY_W-1:0] key,
                                             input logic tile_last);
    tile_code_t code;
    bit         hit;
    code = '0;
    hit  = 1'b0;
    for (int i = 0; i < entry_count && !hit; i++) begin
      if (palette[i] == key) begin
        code.index = IDX_W'(i);
        hit        = 1'b1;
      end
    end
    if (hit) begin
      n_repeat++;
    end else if (entry_count < PALETTE_CAP) begin
      palette[entry_count] = key;
      code.index = IDX_W'(entry_count);
      code.fresh = 1'b1;
      entry_count++;
      n_fresh++;
    end else begin
      code.overflow = 1'b1;
      n_overflow++;
    end
    code.end_of_map = tile_last;
    if (tile_last) begin
      entry_count = 0;
      n_maps++;
    end
    return code;
  endfunction

  // Receiver: random tready, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: each beat against the oldest expected code
  always @(posedge clk) begin
    tile_code_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_codes.size() == 0) begin
        $error("result beat with nothing pending: index %0d tuser %b last %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        error_count++;
      end else begin
        want = pending_codes.pop_front();
        if (m_axis_tdata !== want.index) begin
          $error("palette_index: expected %0d, got %0d", want.index, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.fresh) begin
          $error("new_entry: expected %0b, got %0b", want.fresh, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tuser[1] !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, m_axis_tuser[1]);
          error_count++;
        end
        if (m_axis_tlast !== want.end_of_map) begin
          $error("end_of_map: expected %0b, got %0b", want.end_of_map, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // One tile beat; an idle gap may come first. Returns at the accept edge
  // with tvalid still high, so back-to-back beats need no second assignment.
  task automatic send_tile(input logic [KEY_W-1:0] key, input logic tile_last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tlast  <= tile_last;
    do @(posedge clk); while (!s_axis_tready);
    pending_codes = {pending_codes, encode_tile(key, tile_last)};
    n_beats++;
  endtask

  // Sender pause: drop tvalid and wait for every pending result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Corner tiles: field extremes, single-bit differences, hits, and the
  // table emptying after a last tile (hit, miss and one-tile maps)
  task automatic test_corner_tiles();
    send_tile(24'h000000, 1'b0);   // first entry, index 0
    send_tile(24'hFFFFFF, 1'b0);
    send_tile(24'h000000, 1'b0);   // repeat of entry 0
    send_tile(24'h000001, 1'b0);
    send_tile(24'h000100, 1'b0);
    send_tile(24'h010000, 1'b0);
    send_tile(24'h800000, 1'b0);
    send_tile(24'hAA55AA, 1'b0);
    send_tile(24'h55AA55, 1'b0);
    send_tile(24'h000100, 1'b0);
    send_tile(24'hFFFFFF, 1'b1);   // last tile that hits
    send_tile(24'hFFFFFF, 1'b0);   // fresh map: new again at index 0
    send_tile(24'h000000, 1'b1);   // last tile that misses
    send_tile(24'h563412, 1'b1);   // one-tile map
    send_tile(24'h563412, 1'b1);   // same tile, still new
    send_tile(24'h7F7F7F, 1'b0);
    send_tile(24'h7F7F7F, 1'b0);
    send_tile(24'h7F7F7E, 1'b1);
  endtask

  // Fill the whole table, then overflow, hit both ends, and end the map on
  // an overflowing tile; the next map must start empty
  task automatic test_full_table();
    logic [KEY_W-1:0] fill_keys [PALETTE_CAP];
    logic [7:0]       col_mask;
    col_mask = 8'($urandom);
    for (int i = 0; i < PALETTE_CAP; i++) begin
      fill_keys[i] = {8'($urandom), 8'($urandom), 8'(i) ^ col_mask};
      send_tile(fill_keys[i], 1'b0);
    end
    for (int i = 0; i < 4; i++) send_tile(24'($urandom), 1'b0);
    send_tile(fill_keys[0], 1'b0);
    send_tile(fill_keys[PALETTE_CAP - 1], 1'b0);
    send_tile(fill_keys[$urandom_range(PALETTE_CAP - 1)], 1'b0);
    send_tile(24'($urandom), 1'b0);
    send_tile(~fill_keys[3], 1'b1);
    send_tile(fill_keys[5], 1'b0);
    send_tile(fill_keys[5], 1'b1);
  endtask

  // Random maps from small triple pools so repeats are common; now and then
  // a long map, longer than the table, draws on a wide pool
  task automatic test_random_maps(input int tile_target);
    logic [KEY_W-1:0] pool [$];
    int               map_len;
    int               pool_len;
    int               sent;
    sent = 0;
    while (sent < tile_target) begin
      if ($urandom_range(24) == 0) begin
        map_len  = $urandom_range(PALETTE_CAP + 40, PALETTE_CAP + 4);
        pool_len = PALETTE_CAP + 60;
      end else begin
        map_len  = $urandom_range(48, 1);
        pool_len = $urandom_range(64, 1);
      end
      pool.delete();
      for (int i = 0; i < pool_len; i++) pool = {pool, 24'($urandom)};
      for (int t = 0; t < map_len; t++) begin
        if ($urandom_range(99) < 80)
          send_tile(pool[$urandom_range(pool_len - 1)], t == map_len - 1);
        else
          send_tile(24'($urandom), t == map_len - 1);
        sent++;
      end
    end
  endtask

  // Receiver holds off while tiles keep coming, so the block backs up and
  // drops s_axis_tready; afterwards the sender waits for a full drain
  task automatic test_result_holdoff();
    logic [KEY_W-1:0] pool [4];
    int               keep_pct;
    keep_pct      = send_idle_pct;
    send_idle_pct = 0;
    foreach (pool[i]) pool[i] = 24'($urandom);
    hold_req <= ~hold_req;
    for (int t = 0; t < 12; t++) send_tile(pool[$urandom_range(3)], t == 11);
    drain_results();
    send_idle_pct = keep_pct;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_idling(14, 81);
    test_corner_tiles();
    test_full_table();
    test_random_maps(400);
    drain_results();

    set_idling(81, 14);
    test_random_maps(400);
    test_full_table();
    test_result_holdoff();

    set_idling(0, 0);
    test_random_maps(400);
    test_result_holdoff();

    // catch any stray beat after the last expected one
    drain_results();
    repeat (SCAN_CYCLES) @(posedge clk);

    $display("Covered %0d tile beats in %0d maps: %0d new entries, %0d repeats, %0d overflows",
             n_beats, n_maps, n_fresh, n_repeat, n_overflow);
    $display("Idle mixes 14/81, 81/14 and none, with long result hold-offs and drain pauses");
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_mem.sv
hw/rtl/tpd_ctrl.sv
hw/rtl/tile_palette_dedup_encoder_unit.sv
hw/rtl/tpd_checker.sv
tb/sv/tb_tile_palette_dedup_encoder_unit.sv
